>>> rtl/core/animation_timing_progress_assert.svh
// assertion macros for the checker
`ifndef ANIMATION_TIMING_PROGRESS_ASSERT_SVH
`define ANIMATION_TIMING_PROGRESS_ASSERT_SVH

// clocked assertion, off while reset is low
`define ATP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define ATP_ASSERT_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/atp_pkg.sv
package atp_pkg;

    localparam int NUM_BEGINS = 4;
    localparam int FRAC_BITS  = 16;

    localparam int TIME_W  = 32;
    localparam int DUR_W   = 24;
    localparam int REP_W   = 16;
    localparam int CNT_W   = 3;
    localparam int PROG_W  = FRAC_BITS + 1;
    localparam int LIMIT_W = DUR_W + REP_W;
    localparam int SEL_W   = (NUM_BEGINS > 1) ? $clog2(NUM_BEGINS) : 1;
    localparam int DCNT_W  = $clog2(TIME_W + 1);

    localparam int ADDR_W = 5;
    localparam int APB_W  = 32;

    localparam int IN_TDATA_W  = ((3 * TIME_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((PROG_W + 1 + 7) / 8) * 8;

    localparam logic [PROG_W-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

    localparam logic ACTION_CHAIN = 1'b1;

    typedef enum logic [2:0] {
        REG_DURATION    = 3'd0,
        REG_REPEAT      = 3'd1,
        REG_FOREVER     = 3'd2,
        REG_BEGIN_COUNT = 3'd3,
        REG_BEGIN_A     = 3'd4,
        REG_BEGIN_B     = 3'd5,
        REG_BEGIN_C     = 3'd6,
        REG_BEGIN_D     = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [DUR_W-1:0]                  duration;
        logic [REP_W-1:0]                  repeat_periods;
        logic                              repeat_forever;
        logic [CNT_W-1:0]                  begin_count;
        logic [NUM_BEGINS-1:0][TIME_W-1:0] begin_times;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic search_inc;
        logic search_take;
        logic eval_capture;
        logic res_end;
        logic res_zero;
        logic res_full;
        logic res_frac;
        logic div_mod;
        logic div_frac_e;
        logic div_frac_r;
        logic div_step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic action;
        logic active;
        logic search_end;
        logic hit;
        logic dur_zero;
        logic early;
        logic le;
        logic eq;
        logic later_ok;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

>>> rtl/core/atp_regs.sv
module atp_regs import atp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [DUR_W-1:0]  r_duration;
    logic [REP_W-1:0]  r_repeat;
    logic              r_forever;
    logic [CNT_W-1:0]  r_begin_count;
    logic [NUM_BEGINS-1:0][TIME_W-1:0] r_begin;

    t_reg_idx         reg_idx;
    logic [CNT_W-1:0] begin_off;
    logic             begin_ok;
    logic             wr_en;

    assign reg_idx   = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign begin_off = CNT_W'(reg_idx) - CNT_W'(REG_BEGIN_A);
    assign begin_ok  = begin_off < CNT_W'(NUM_BEGINS);
    assign wr_en     = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duration    <= '0;
            r_repeat      <= REP_W'(1);
            r_forever     <= 1'b0;
            r_begin_count <= '0;
            r_begin       <= '0;
        end else if (wr_en) begin
            case (reg_idx) inside
                REG_DURATION:    r_duration    <= pwdata[DUR_W-1:0];
                REG_REPEAT:      r_repeat      <= pwdata[REP_W-1:0];
                REG_FOREVER:     r_forever     <= pwdata[0];
                REG_BEGIN_COUNT: r_begin_count <= pwdata[CNT_W-1:0];
                [REG_BEGIN_A:REG_BEGIN_D]: begin
                    if (begin_ok) begin
                        r_begin[begin_off[SEL_W-1:0]] <= pwdata[TIME_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx) inside
            REG_DURATION:    prdata = APB_W'(r_duration);
            REG_REPEAT:      prdata = APB_W'(r_repeat);
            REG_FOREVER:     prdata = APB_W'(r_forever);
            REG_BEGIN_COUNT: prdata = APB_W'(r_begin_count);
            [REG_BEGIN_A:REG_BEGIN_D]: begin
                if (begin_ok) begin
                    prdata = APB_W'(r_begin[begin_off[SEL_W-1:0]]);
                end
            end
            default: prdata = '0;
        endcase
    end

    assign o_cfg.duration       = r_duration;
    assign o_cfg.repeat_periods = r_repeat;
    assign o_cfg.repeat_forever = r_forever;
    assign o_cfg.begin_count    = r_begin_count;
    assign o_cfg.begin_times    = r_begin;

endmodule

>>> rtl/core/atp_div.sv
module atp_div import atp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  logic                 i_step,
    input  logic [DUR_W-1:0]     i_rem_init,
    input  logic [TIME_W-1:0]    i_src_init,
    input  logic [DCNT_W-1:0]    i_cnt_init,
    input  logic [DUR_W-1:0]     i_divisor,
    output logic [DUR_W-1:0]     o_rem,
    output logic [FRAC_BITS-1:0] o_quot,
    output logic                 o_done
);

    logic [DUR_W-1:0]     r_rem;
    logic [TIME_W-1:0]    r_src;
    logic [FRAC_BITS-1:0] r_quot;
    logic [DCNT_W-1:0]    r_cnt;

    logic [DUR_W:0] trial;
    logic [DUR_W:0] diff;
    logic           ge;

    // restoring step: shift one dividend bit into the partial remainder
    assign trial = {r_rem, r_src[TIME_W-1]};
    assign diff  = trial - {1'b0, i_divisor};
    assign ge    = trial >= {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_cnt_init;
        end else if (i_step && (r_cnt != '0)) begin
            r_cnt <= r_cnt - DCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem  <= i_rem_init;
            r_src  <= i_src_init;
            r_quot <= '0;
        end else if (i_step && (r_cnt != '0)) begin
            r_rem  <= ge ? diff[DUR_W-1:0] : trial[DUR_W-1:0];
            r_src  <= {r_src[TIME_W-2:0], 1'b0};
            r_quot <= {r_quot[FRAC_BITS-2:0], ge};
        end
    end

    assign o_rem  = r_rem;
    assign o_quot = r_quot;
    assign o_done = (r_cnt == '0);

endmodule

>>> rtl/core/atp_dpath.sv
module atp_dpath import atp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  t_cmd                   i_cmd,
    input  logic [IN_TDATA_W-1:0]  i_in_tdata,
    input  logic                   i_in_tuser,
    input  logic                   i_out_ready,
    output t_sts                   o_sts,
    output logic                   o_out_valid,
    output logic [OUT_TDATA_W-1:0] o_out_tdata,
    output logic                   o_out_tuser,
    output logic                   o_out_tlast
);

    logic [TIME_W-1:0] in_prev;
    logic [TIME_W-1:0] in_now;
    logic [TIME_W-1:0] in_chain;
    logic              rewind;

    logic [TIME_W-1:0]  r_t_now;
    logic               r_active;
    logic [TIME_W-1:0]  r_run_begin;
    logic [CNT_W-1:0]   r_idx;
    logic [TIME_W-1:0]  r_elapsed;
    logic [LIMIT_W-1:0] r_limit;
    logic               r_res_valid;
    logic [PROG_W-1:0]  r_res_prog;
    logic               r_res_ended;
    logic               r_out_valid;
    logic               r_out_pv;
    logic [PROG_W-1:0]  r_out_prog;
    logic               r_out_running;
    logic               r_out_ended;

    logic [CNT_W-1:0]   n_eff;
    logic [TIME_W-1:0]  bt;
    logic [TIME_W:0]    win_end;
    logic [TIME_W-1:0]  elapsed;
    logic [REP_W-1:0]   periods;
    logic [TIME_W-1:0]  dur_t;

    logic                 div_load;
    logic [DUR_W-1:0]     div_rem_init;
    logic [TIME_W-1:0]    div_src_init;
    logic [DCNT_W-1:0]    div_cnt_init;
    logic [DUR_W-1:0]     div_rem;
    logic [FRAC_BITS-1:0] div_quot;
    logic                 div_done;

    assign in_prev  = i_in_tdata[TIME_W-1:0];
    assign in_now   = i_in_tdata[2*TIME_W-1:TIME_W];
    assign in_chain = i_in_tdata[3*TIME_W-1:2*TIME_W];
    assign rewind   = (i_in_tuser != ACTION_CHAIN) && (in_prev == '0) && (in_now == '0);

    assign n_eff = (i_cfg.begin_count > CNT_W'(NUM_BEGINS)) ? CNT_W'(NUM_BEGINS)
                                                            : i_cfg.begin_count;
    assign bt      = i_cfg.begin_times[r_idx[SEL_W-1:0]];
    assign win_end = {1'b0, bt} + (TIME_W+1)'(i_cfg.duration);
    assign elapsed = r_t_now - r_run_begin;
    assign periods = (i_cfg.repeat_periods == '0) ? REP_W'(1) : i_cfg.repeat_periods;
    assign dur_t   = TIME_W'(i_cfg.duration);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_run_begin <= '0;
            r_idx       <= '0;
        end else begin
            if (i_cmd.load) begin
                r_idx <= '0;
                if (i_in_tuser == ACTION_CHAIN) begin
                    r_active    <= 1'b1;
                    r_run_begin <= in_chain;
                end else if (rewind) begin
                    r_active <= 1'b0;
                end
            end
            if (i_cmd.search_inc) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (i_cmd.search_take) begin
                r_active    <= 1'b1;
                r_run_begin <= bt;
            end
            if (i_cmd.res_end) begin
                r_active <= 1'b0;
            end
        end
    end

    // item payload and the staged result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_t_now     <= in_now;
            r_res_valid <= (i_in_tuser == ACTION_CHAIN) || rewind;
            r_res_prog  <= '0;
            r_res_ended <= 1'b0;
        end
        if (i_cmd.eval_capture) begin
            r_elapsed <= elapsed;
            r_limit   <= LIMIT_W'(periods) * LIMIT_W'(i_cfg.duration);
        end
        if (i_cmd.res_end) begin
            r_res_valid <= 1'b1;
            r_res_prog  <= ONE_Q;
            r_res_ended <= 1'b1;
        end
        if (i_cmd.res_zero) begin
            r_res_valid <= 1'b1;
            r_res_prog  <= '0;
        end
        if (i_cmd.res_full) begin
            r_res_valid <= 1'b1;
            r_res_prog  <= ONE_Q;
        end
        if (i_cmd.res_frac) begin
            r_res_valid <= 1'b1;
            r_res_prog  <= PROG_W'(div_quot);
        end
    end

    // modulo pass loads the elapsed time, fraction pass starts from the first-period elapsed time or a remainder
    assign div_load     = i_cmd.div_mod || i_cmd.div_frac_e || i_cmd.div_frac_r;
    assign div_rem_init = i_cmd.div_mod    ? '0 :
                          i_cmd.div_frac_e ? r_elapsed[DUR_W-1:0] : div_rem;
    assign div_src_init = i_cmd.div_mod ? r_elapsed : '0;
    assign div_cnt_init = i_cmd.div_mod ? DCNT_W'(TIME_W) : DCNT_W'(FRAC_BITS);

    atp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (div_load),
        .i_step     (i_cmd.div_step),
        .i_rem_init (div_rem_init),
        .i_src_init (div_src_init),
        .i_cnt_init (div_cnt_init),
        .i_divisor  (i_cfg.duration),
        .o_rem      (div_rem),
        .o_quot     (div_quot),
        .o_done     (div_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_pv      <= r_res_valid;
            r_out_prog    <= r_res_prog;
            r_out_running <= r_active;
            r_out_ended   <= r_res_ended;
        end
    end

    assign o_sts.action     = (i_in_tuser == ACTION_CHAIN);
    assign o_sts.active     = r_active;
    assign o_sts.search_end = (r_idx >= n_eff);
    assign o_sts.hit        = (bt <= r_t_now) && ({1'b0, r_t_now} <= win_end);
    assign o_sts.dur_zero   = (i_cfg.duration == '0);
    assign o_sts.early      = (r_t_now < r_run_begin);
    assign o_sts.le         = (r_elapsed <= dur_t);
    assign o_sts.eq         = (r_elapsed == dur_t);
    assign o_sts.later_ok   = i_cfg.repeat_forever || (LIMIT_W'(r_elapsed) < r_limit);
    assign o_sts.div_done   = div_done;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_tdata = OUT_TDATA_W'({r_out_running, r_out_prog});
    assign o_out_tuser = r_out_pv;
    assign o_out_tlast = r_out_ended;

endmodule

>>> rtl/core/atp_ctrl.sv
module atp_ctrl import atp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SEARCH = 7'b0000010,
        S_EVAL   = 7'b0000100,
        S_CMP    = 7'b0001000,
        S_MOD    = 7'b0010000,
        S_FRAC   = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.action ? S_DONE : S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (i_sts.active) begin
                    n_state = S_EVAL;
                end else if (i_sts.search_end) begin
                    n_state = S_DONE;
                end else if (i_sts.hit) begin
                    o_cmd.search_take = 1'b1;
                    n_state           = S_EVAL;
                end else begin
                    o_cmd.search_inc = 1'b1;
                end
            end
            S_EVAL: begin
                if (i_sts.dur_zero) begin
                    o_cmd.res_end = 1'b1;
                    n_state       = S_DONE;
                end else if (i_sts.early) begin
                    o_cmd.res_zero = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.eval_capture = 1'b1;
                    n_state            = S_CMP;
                end
            end
            S_CMP: begin
                if (i_sts.le) begin
                    // a full first period is exactly 1.0
                    if (i_sts.eq) begin
                        o_cmd.res_full = 1'b1;
                        n_state        = S_DONE;
                    end else begin
                        o_cmd.div_frac_e = 1'b1;
                        n_state          = S_FRAC;
                    end
                end else if (i_sts.later_ok) begin
                    o_cmd.div_mod = 1'b1;
                    n_state       = S_MOD;
                end else begin
                    o_cmd.res_end = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_MOD: begin
                if (i_sts.div_done) begin
                    o_cmd.div_frac_r = 1'b1;
                    n_state          = S_FRAC;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_FRAC: begin
                if (i_sts.div_done) begin
                    o_cmd.res_frac = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/core/animation_timing_progress.sv
// path, accepted beat to o_m_tvalid: a chained start goes to S_DONE; a tick passes S_SEARCH
// (left at once when running, else one begin time tested per step and a last step on no match),
// then a miss goes to S_DONE, zero duration or a time ahead of the begin pass S_EVAL, a full
// period or the end S_EVAL and S_CMP, the first period also S_FRAC, later ones S_MOD and S_FRAC
// S_DONE waits on the output; one beat in flight, the next is taken in the cycle o_m_tvalid rises
// reset: synchronous active low, clears run state and loads register defaults, no clear pass
module animation_timing_progress import atp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // time_prev [31:0], time_now [63:32], chain_start_at [95:64]
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // action
    input  logic                   i_s_tuser,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // progress [16:0], running [17], zero fill
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    // progress_valid
    output logic                   o_m_tuser,
    // ended
    output logic                   o_m_tlast,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [APB_W-1:0]       pwdata,
    output logic [APB_W-1:0]       prdata,
    output logic                   pready
);

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    atp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    atp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_sts      (sts),
        .o_in_ready (o_s_tready),
        .o_cmd      (cmd)
    );

    atp_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .i_in_tdata  (i_s_tdata),
        .i_in_tuser  (i_s_tuser),
        .i_out_ready (i_m_tready),
        .o_sts       (sts),
        .o_out_valid (o_m_tvalid),
        .o_out_tdata (o_m_tdata),
        .o_out_tuser (o_m_tuser),
        .o_out_tlast (o_m_tlast)
    );

endmodule

>>> rtl/core/atp_checker.sv
`include "animation_timing_progress_assert.svh"

module atp_checker import atp_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_s_tready,
    input logic                   o_m_tvalid,
    input logic [OUT_TDATA_W-1:0] o_m_tdata,
    input logic                   o_m_tuser,
    input logic                   o_m_tlast
);

    // an ending beat carries 1.0 and leaves the run stopped
    `ATP_ASSERT(a_end_full, i_clk, i_rst_n, o_m_tvalid && o_m_tlast |-> o_m_tuser && !o_m_tdata[PROG_W] && (o_m_tdata[PROG_W-1:0] == ONE_Q), "ended beat without full progress or still running")

    // no progress means an idle block with an all-zero beat
    `ATP_ASSERT(a_idle_zero, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser |-> (o_m_tdata == '0) && !o_m_tlast, "beat without progress carries data")

    `ATP_ASSERT(a_prog_range, i_clk, i_rst_n, o_m_tvalid |-> (o_m_tdata[PROG_W-1:0] <= ONE_Q), "progress above one")

    `ATP_ASSERT_NORST(a_reset_state, i_clk, !i_rst_n |=> !o_m_tvalid && o_s_tready, "block not idle after reset")

endmodule

bind animation_timing_progress atp_checker u_atp_checker (.*);

>>> sim/animation_timing_progress_test.sv
module animation_timing_progress_test;
    timeunit 1ns;
    timeprecision 1ps;
    import atp_pkg::*;

    localparam int  IDLE_LIMIT    = 5000;
    localparam int  HOLD_CYCLES   = 400;
    localparam int  SETTLE_CYCLES = 100;
    localparam int  PHASES        = 12;
    localparam int  PHASE_ITEMS   = 40;
    localparam int  HOLD_PHASE    = 3;
    localparam logic ACTION_TICK  = ~ACTION_CHAIN;

    typedef struct packed {
        logic              valid;
        logic [PROG_W-1:0] progress;
        logic              running;
        logic              ended;
    } t_progress;

    typedef enum logic {ROW_BEAT, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind         kind;
        t_reg_idx          reg_idx;
        logic [31:0]       reg_value;
        logic              action;
        logic [TIME_W-1:0] time_prev;
        logic [TIME_W-1:0] time_now;
        logic [TIME_W-1:0] chain_at;
        logic              typed;
        t_progress         want;
    } t_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tready = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [ADDR_W-1:0]      paddr = '0;
    logic [APB_W-1:0]       pwdata = '0;
    logic                   o_s_tready;
    logic                   o_m_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tuser;
    logic                   o_m_tlast;
    logic [APB_W-1:0]       prdata;
    logic                   pready;

    // own copy of the register file and the run state
    t_cfg              model_cfg;
    logic              run_active;
    logic [TIME_W-1:0] run_start;

    t_progress progress_due[$];
    t_row      plan[$];

    int errors = 0;
    int beats_sent = 0;
    int chains_sent = 0;
    int rewinds_sent = 0;
    int results_seen = 0;
    int runs_ended = 0;
    int cfg_writes = 0;
    int burst_left = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int quiet = 0;
    int stall_mode = 0;
    int stall_left = 0;

    animation_timing_progress DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #2ns i_clk = 1'b1;
        #2ns i_clk = 1'b0;
    end

    function automatic t_progress predict_progress(input logic act,
                                                   input logic [TIME_W-1:0] t_prev,
                                                   input logic [TIME_W-1:0] t_now,
                                                   input logic [TIME_W-1:0] chain_at);
        t_progress   r;
        logic [63:0] dur;
        logic [63:0] now64;
        logic [63:0] start64;
        logic [63:0] bt;
        logic [63:0] elapsed;
        logic [63:0] periods;
        logic [63:0] q;
        int          n;
        logic        found;
        r = '0;
        dur = {40'd0, model_cfg.duration};
        now64 = {32'd0, t_now};
        if (act == ACTION_CHAIN) begin
            run_active = 1'b1;
            run_start = chain_at;
            r.valid = 1'b1;
        end else begin
            if (t_prev == '0 && t_now == '0) begin
                r.valid = 1'b1;
                run_active = 1'b0;
            end
            if (!run_active) begin
                n = (model_cfg.begin_count > NUM_BEGINS) ? NUM_BEGINS : model_cfg.begin_count;
                found = 1'b0;
                for (int i = 0; i < NUM_BEGINS; i++) begin
                    bt = {32'd0, model_cfg.begin_times[i]};
                    // window end is formed 33 bits wide, no wrap
                    if (!found && i < n && bt <= now64 && now64 <= bt + dur) begin
                        found = 1'b1;
                        run_active = 1'b1;
                        run_start = model_cfg.begin_times[i];
                    end
                end
            end
            if (run_active) begin
                r.valid = 1'b1;
                start64 = {32'd0, run_start};
                if (dur == 0) begin
                    r.progress = ONE_Q;
                    r.ended = 1'b1;
                    run_active = 1'b0;
                end else if (now64 < start64) begin
                    r.progress = '0;
                end else begin
                    elapsed = now64 - start64;
                    periods = (model_cfg.repeat_periods == '0) ? 64'd1
                                                               : {48'd0, model_cfg.repeat_periods};
                    if (elapsed <= dur) begin
                        q = (elapsed << FRAC_BITS) / dur;
                        r.progress = q[PROG_W-1:0];
                    end else if (model_cfg.repeat_forever || elapsed < periods * dur) begin
                        q = ((elapsed % dur) << FRAC_BITS) / dur;
                        r.progress = q[PROG_W-1:0];
                    end else begin
                        r.progress = ONE_Q;
                        r.ended = 1'b1;
                        run_active = 1'b0;
                    end
                end
            end
        end
        r.running = run_active;
        return r;
    endfunction

    task automatic add_cfg(input t_reg_idx idx, input logic [31:0] value);
        t_row row;
        row = '{kind: ROW_CFG, reg_idx: idx, default: '0};
        row.kind = ROW_CFG;
        row.reg_idx = idx;
        row.reg_value = value;
        plan.push_back(row);
    endtask

    task automatic add_beat(input logic act, input logic [31:0] t_prev, input logic [31:0] t_now,
                            input logic [31:0] chain_at, input logic typed, input logic v,
                            input logic [PROG_W-1:0] prog, input logic run, input logic fin);
        t_row row;
        row = '{kind: ROW_BEAT, reg_idx: REG_DURATION, default: '0};
        row.kind = ROW_BEAT;
        row.action = act;
        row.time_prev = t_prev;
        row.time_now = t_now;
        row.chain_at = chain_at;
        row.typed = typed;
        row.want.valid = v;
        row.want.progress = prog;
        row.want.running = run;
        row.want.ended = fin;
        plan.push_back(row);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_DURATION:    model_cfg.duration = value[DUR_W-1:0];
            REG_REPEAT:      model_cfg.repeat_periods = value[REP_W-1:0];
            REG_FOREVER:     model_cfg.repeat_forever = value[0];
            REG_BEGIN_COUNT: model_cfg.begin_count = value[CNT_W-1:0];
            REG_BEGIN_A:     model_cfg.begin_times[0] = value;
            REG_BEGIN_B:     model_cfg.begin_times[1] = value;
            REG_BEGIN_C:     model_cfg.begin_times[2] = value;
            REG_BEGIN_D:     model_cfg.begin_times[3] = value;
            default: ;
        endcase
        cfg_writes++;
        @(posedge i_clk);
    endtask

    // lowers valid, then waits until every expected progress beat is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (progress_due.size() != 0);
    endtask

    task automatic send_beat(input logic act, input logic [TIME_W-1:0] t_prev,
                             input logic [TIME_W-1:0] t_now, input logic [TIME_W-1:0] chain_at,
                             input logic typed, input t_progress want);
        t_progress model_res;
        int        gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {chain_at, t_now, t_prev};
        do @(posedge i_clk); while (!o_s_tready);
        model_res = predict_progress(act, t_prev, t_now, chain_at);
        progress_due.push_back(typed ? want : model_res);
        beats_sent++;
        if (act == ACTION_CHAIN)
            chains_sent++;
        else if (t_prev == '0 && t_now == '0)
            rewinds_sent++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // receiver: own stall pattern, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_mode <= $urandom_range(0, 2);
                stall_left <= $urandom_range(16, 128);
            end else begin
                stall_left <= stall_left - 1;
            end
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= $urandom_range(0, 1);
                default: m_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin : check_results
        t_progress seen;
        t_progress due;
        if (i_rst_n && o_m_tvalid && m_tready) begin
            seen.valid = o_m_tuser;
            seen.progress = o_m_tdata[PROG_W-1:0];
            seen.running = o_m_tdata[PROG_W];
            seen.ended = o_m_tlast;
            results_seen++;
            if (seen.ended === 1'b1)
                runs_ended++;
            if (progress_due.size() == 0) begin
                $display("%0t: progress beat with nothing expected, got valid %0b progress %0d",
                         $time, seen.valid, seen.progress);
                errors++;
            end else begin
                due = progress_due.pop_front();
                check_field("progress_valid", 32'(due.valid), 32'(seen.valid));
                check_field("progress", 32'(due.progress), 32'(seen.progress));
                check_field("running", 32'(due.running), 32'(seen.running));
                check_field("ended", 32'(due.ended), 32'(seen.ended));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready) || psel) begin
            quiet <= 0;
        end else if (quiet >= IDLE_LIMIT) begin
            $display("%0t: watchdog, no beat for %0d cycles, %0d results outstanding",
                     $time, IDLE_LIMIT, progress_due.size());
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin : stimulus
        t_row        row;
        logic [31:0] dur_pick;
        logic [31:0] anchor;
        logic [31:0] cur_t;
        logic [31:0] prev_t;
        logic [31:0] span;
        logic [31:0] bt_pick[NUM_BEGINS];
        int          pick;

        model_cfg = '0;
        model_cfg.repeat_periods = 1;
        run_active = 1'b0;
        run_start = '0;

        // after reset: zero duration, no begin times in use
        add_beat(ACTION_TICK, 5, 10, 0, 1, 1'b0, '0, 1'b0, 1'b0);
        add_beat(ACTION_TICK, 0, 0, 0, 1, 1'b1, '0, 1'b0, 1'b0);
        add_beat(ACTION_CHAIN, 7, 8, 100, 1, 1'b1, '0, 1'b1, 1'b0);
        add_beat(ACTION_TICK, 100, 200, 0, 1, 1'b1, ONE_Q, 1'b0, 1'b1);
        add_cfg(REG_DURATION, 1000);
        add_cfg(REG_REPEAT, 3);
        add_cfg(REG_BEGIN_COUNT, 4);
        add_cfg(REG_BEGIN_A, 100000);
        add_cfg(REG_BEGIN_B, 5000);
        add_cfg(REG_BEGIN_C, 32'hFFFF_FFFF);
        add_cfg(REG_BEGIN_D, 0);
        // second begin time wins at its window end, then later periods and the end
        add_beat(ACTION_TICK, 4000, 6000, 0, 0, 0, '0, 0, 0);
        add_beat(ACTION_TICK, 6000, 6500, 0, 0, 0, '0, 0, 0);
        add_beat(ACTION_TICK, 6500, 8000, 0, 0, 0, '0, 0, 0);
        add_beat(ACTION_TICK, 8000, 100500, 0, 0, 0, '0, 0, 0);
        // restart while running, then a tick ahead of the new begin
        add_beat(ACTION_CHAIN, 100500, 100600, 200000, 1, 1'b1, '0, 1'b1, 1'b0);
        add_beat(ACTION_TICK, 100600, 150000, 0, 0, 0, '0, 0, 0);
        add_beat(ACTION_TICK, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 0, 0, 0, '0, 0, 0);
        // window past the top of the time range
        add_beat(ACTION_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, '0, 0, 0);
        // rewind while running, search again at time zero
        add_beat(ACTION_TICK, 0, 0, 32'hFFFF_FFFF, 0, 0, '0, 0, 0);
        add_cfg(REG_FOREVER, 1);
        add_cfg(REG_REPEAT, 0);
        add_beat(ACTION_TICK, 0, 999999, 0, 0, 0, '0, 0, 0);
        add_cfg(REG_DURATION, 32'h00FF_FFFF);
        add_cfg(REG_FOREVER, 0);
        add_cfg(REG_REPEAT, 32'h0000_FFFF);
        add_beat(ACTION_TICK, 999999, 32'h00FF_FFFF, 0, 0, 0, '0, 0, 0);
        add_beat(ACTION_TICK, 32'h00FF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, '0, 0, 0);
        // zero repeat plays a single period
        add_cfg(REG_DURATION, 10);
        add_cfg(REG_REPEAT, 0);
        add_beat(ACTION_CHAIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1, 1'b1, '0, 1'b1, 1'b0);
        add_beat(ACTION_TICK, 0, 10, 0, 0, 0, '0, 0, 0);
        add_beat(ACTION_TICK, 10, 11, 0, 0, 0, '0, 0, 0);
        add_cfg(REG_BEGIN_COUNT, 0);
        add_beat(ACTION_TICK, 0, 0, 0, 1, 1'b1, '0, 1'b0, 1'b0);
        // begin count above the number of begin registers
        add_cfg(REG_BEGIN_COUNT, 7);
        add_beat(ACTION_TICK, 3, 5, 0, 0, 0, '0, 0, 0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[r]) begin
            row = plan[r];
            if (row.kind == ROW_CFG) begin
                drain_results();
                write_reg(row.reg_idx, row.reg_value);
            end else begin
                send_beat(row.action, row.time_prev, row.time_now, row.chain_at,
                          row.typed, row.want);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            drain_results();
            case ($urandom_range(0, 9))
                0: dur_pick = 0;
                1: dur_pick = 1;
                2: dur_pick = 32'h00FF_FFFF;
                3: dur_pick = $urandom_range(0, 32'h00FF_FFFF);
                default: dur_pick = $urandom_range(2, 3000);
            endcase
            anchor = $urandom;
            for (int i = 0; i < NUM_BEGINS; i++) begin
                case ($urandom_range(0, 9))
                    0: bt_pick[i] = 0;
                    1: bt_pick[i] = 32'hFFFF_FFFF;
                    2: bt_pick[i] = $urandom;
                    default: bt_pick[i] = anchor + $urandom_range(0, dur_pick * 3 + 100);
                endcase
            end
            write_reg(REG_DURATION, dur_pick);
            case ($urandom_range(0, 7))
                0: write_reg(REG_REPEAT, 0);
                1: write_reg(REG_REPEAT, 1);
                2: write_reg(REG_REPEAT, 32'h0000_FFFF);
                3: write_reg(REG_REPEAT, $urandom_range(0, 32'h0000_FFFF));
                default: write_reg(REG_REPEAT, $urandom_range(2, 6));
            endcase
            write_reg(REG_FOREVER, 32'($urandom_range(0, 3) == 0));
            write_reg(REG_BEGIN_COUNT, ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7)
                                                                   : $urandom_range(0, 4));
            write_reg(REG_BEGIN_A, bt_pick[0]);
            write_reg(REG_BEGIN_B, bt_pick[1]);
            write_reg(REG_BEGIN_C, bt_pick[2]);
            write_reg(REG_BEGIN_D, bt_pick[3]);
            if (phase == HOLD_PHASE)
                hold_requests <= hold_requests + 1;
            cur_t = anchor - $urandom_range(0, 50);

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 68) begin
                    // well-formed tick sequence moving forward through the run
                    span = (($urandom_range(0, 5) == 0) ? dur_pick * 3 : dur_pick / 4) + 2;
                    prev_t = cur_t;
                    cur_t = cur_t + $urandom_range(0, span);
                    send_beat(ACTION_TICK, prev_t, cur_t, $urandom, 0, '0);
                end else if (pick < 78) begin
                    if ($urandom_range(0, 3) == 0)
                        prev_t = $urandom;
                    else
                        prev_t = cur_t + $urandom_range(0, 40) - 20;
                    send_beat(ACTION_CHAIN, $urandom, $urandom, prev_t, 0, '0);
                end else if (pick < 84) begin
                    send_beat(ACTION_TICK, 0, 0, $urandom, 0, '0);
                end else if (pick < 90) begin
                    // jump back to just ahead of one of the begin times
                    cur_t = bt_pick[$urandom_range(0, NUM_BEGINS - 1)] - $urandom_range(0, 20);
                    send_beat(ACTION_TICK, $urandom, cur_t, $urandom, 0, '0);
                end else begin
                    send_beat($urandom_range(0, 1), $urandom, $urandom, $urandom, 0, '0);
                end
                if ($urandom_range(0, 49) == 0)
                    drain_results();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("sent %0d beats (%0d chained starts, %0d rewinds) across %0d register writes",
                 beats_sent, chains_sent, rewinds_sent, cfg_writes);
        $display("checked %0d progress beats, %0d of them ended a run", results_seen, runs_ended);
        if (errors == 0 && progress_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
